[hdl/gbn_pkg.sv]
// Shared constants, codes and result control type of the go-back-n sender window.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

    localparam int WINDOW_DEF       = 4;
    localparam int SEQ_SPACE_DEF    = 8;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int SEQ_W  = 3;
    localparam int FUNC_W = 2;
    localparam int KIND_W = 3;

    typedef logic [SEQ_W-1:0]  t_seq;
    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [KIND_W-1:0] t_kind;

    localparam t_func FUNC_SEND    = 2'd0;
    localparam t_func FUNC_ACK     = 2'd1;
    localparam t_func FUNC_TIMEOUT = 2'd2;

    localparam t_kind KIND_SENT    = 3'd0;
    localparam t_kind KIND_REFUSED = 3'd1;
    localparam t_kind KIND_RETX    = 3'd2;
    localparam t_kind KIND_ACKED   = 3'd3;
    localparam t_kind KIND_IGNORED = 3'd4;

    typedef struct packed {
        t_kind kind;
        t_seq  pkt_seq;
        logic  timer_stop;
        t_seq  timer_stop_seq;
        logic  timer_start;
        t_seq  timer_start_seq;
        logic  window_full;
        logic  last;
    } t_res_ctl;

endpackage

`default_nettype wire

[hdl/gbn_ifs.sv]
// Request and result channel interfaces of the go-back-n sender window.
`timescale 1ns / 1ps
`default_nettype none

interface gbn_req_if #(
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
);
    import gbn_pkg::*;

    logic                    valid;
    logic                    ready;
    t_func                   func;
    logic [PAYLOAD_BITS-1:0] payload;
    t_seq                    ack_num;
    logic                    ack_intact;
    t_seq                    timeout_seq;

    modport source (
        output valid, func, payload, ack_num, ack_intact, timeout_seq,
        input  ready
    );
    modport sink (
        input  valid, func, payload, ack_num, ack_intact, timeout_seq,
        output ready
    );
endinterface

interface gbn_rsp_if #(
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
);
    import gbn_pkg::*;

    logic                    valid;
    logic                    ready;
    t_kind                   kind;
    t_seq                    pkt_seq;
    logic [PAYLOAD_BITS-1:0] pkt_payload;
    logic                    timer_stop;
    t_seq                    timer_stop_seq;
    logic                    timer_start;
    t_seq                    timer_start_seq;
    logic                    window_full;
    logic                    last;

    modport source (
        output valid, kind, pkt_seq, pkt_payload, timer_stop, timer_stop_seq,
               timer_start, timer_start_seq, window_full, last,
        input  ready
    );
    modport sink (
        input  valid, kind, pkt_seq, pkt_payload, timer_stop, timer_stop_seq,
               timer_start, timer_start_seq, window_full, last,
        output ready
    );
endinterface

`default_nettype wire

[hdl/gbn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/gbn_out_stage.sv]
// Result register that holds one item for the result channel.
`timescale 1ns / 1ps
`default_nettype none

module gbn_out_stage #(
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  gbn_pkg::t_res_ctl       i_ctl,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                    o_free,
    gbn_rsp_if.source               o_rsp
);
    import gbn_pkg::*;

    logic                    r_valid;
    logic                    n_valid;
    t_res_ctl                r_ctl;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // free when empty or when the held item leaves at this edge
    assign o_free  = !r_valid || o_rsp.ready;
    assign n_valid = i_load || (r_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl     <= i_ctl;
            r_payload <= i_payload;
        end
    end

    assign o_rsp.valid           = r_valid;
    assign o_rsp.kind            = r_ctl.kind;
    assign o_rsp.pkt_seq         = r_ctl.pkt_seq;
    assign o_rsp.pkt_payload     = r_payload;
    assign o_rsp.timer_stop      = r_ctl.timer_stop;
    assign o_rsp.timer_stop_seq  = r_ctl.timer_stop_seq;
    assign o_rsp.timer_start     = r_ctl.timer_start;
    assign o_rsp.timer_start_seq = r_ctl.timer_start_seq;
    assign o_rsp.window_full     = r_ctl.window_full;
    assign o_rsp.last            = r_ctl.last;

endmodule

`default_nettype wire

[hdl/go_back_n_sender_window_core.sv]
// Go-back-n sender window: send, cumulative ack and timeout retransmission.
//
// i_req carries one command item: send a payload, an arriving ack, or a
// retransmission timeout. o_rsp carries result items, each with timer
// stop/start requests and the window-full flag; last marks the final one.
// Payloads of outstanding packets sit in a WINDOW-deep RAM ring.
// A send or an ack gives a single result that is in the output register
// the cycle after acceptance; the next item can be taken in that same
// cycle, so such items flow at one per cycle while o_rsp takes them.
// A timeout with N packets outstanding reads the ring one entry per cycle
// while o_rsp takes the results, through the RAM's registered read port:
// each entry passes the RAM read register, then the output register, and
// i_req stays not ready until the last one is in the output register.
// A refused send, an ignored ack and a timeout with nothing outstanding
// give one result each.
// Reset sets base and next sequence to 1 and empties the window; the RAM
// needs no clearing. When o_rsp stalls the result register holds its item
// and both the ring walk and i_req wait.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_window_core #(
    parameter int WINDOW       = gbn_pkg::WINDOW_DEF,
    parameter int SEQ_SPACE    = gbn_pkg::SEQ_SPACE_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbn_req_if.sink   i_req,
    gbn_rsp_if.source o_rsp
);
    import gbn_pkg::*;

    localparam int SW = $clog2(SEQ_SPACE);
    localparam int OW = $clog2(WINDOW + 1);
    localparam int RW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int XW = OW + 1;
    localparam int CW = ((SW > SEQ_W) ? SW : SEQ_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [SW-1:0]   r_base, n_base;
    logic [SW-1:0]   r_next, n_next;
    logic [OW-1:0]   r_outs, n_outs;
    logic [RW-1:0]   r_head, n_head;
    logic [RW-1:0]   r_waddr, n_waddr;
    logic [SW-1:0]   r_wseq, n_wseq;
    logic [OW-1:0]   r_wcnt, n_wcnt;
    t_seq            r_tseq, n_tseq;

    logic                    s_fire;
    logic                    s_out_free;
    logic                    s_ld;
    t_res_ctl                s_ctl;
    logic [PAYLOAD_BITS-1:0] s_pay;
    logic                    s_wr_en;
    logic [RW-1:0]           s_wr_addr;
    logic                    s_rd_en;
    logic [RW-1:0]           s_rd_addr;
    logic [PAYLOAD_BITS-1:0] s_rd_data;

    logic            s_full;
    logic [SW-1:0]   s_ack;
    logic            s_ack_range;
    logic [SW:0]     s_diff;
    logic [SW:0]     s_dist;
    logic            s_in_win;
    logic [OW-1:0]   s_freed;
    logic [OW-1:0]   s_outs_ack;
    logic [SW-1:0]   s_base_ack;
    logic            s_walk_last;

    function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
        seq_inc = (32'(s) == SEQ_SPACE - 1) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] a,
                                               input logic [OW-1:0] b);
        logic [XW-1:0] sum;
        sum = XW'(a) + XW'(b);
        if (sum >= XW'(WINDOW)) begin
            sum = sum - XW'(WINDOW);
        end
        ring_add = RW'(sum);
    endfunction

    assign i_req.ready = (r_state == S_IDLE) && s_out_free;
    assign s_fire      = i_req.valid && i_req.ready;

    assign s_full    = (r_outs == OW'(WINDOW));
    assign s_wr_addr = ring_add(r_head, r_outs);

    // wrap-aware distance of the ack from the base
    assign s_ack       = SW'(i_req.ack_num);
    assign s_ack_range = CW'(i_req.ack_num) < CW'(SEQ_SPACE);
    assign s_diff      = {1'b0, s_ack} - {1'b0, r_base};
    assign s_dist      = s_diff[SW] ? s_diff + (SW + 1)'(SEQ_SPACE) : s_diff;
    assign s_in_win    = i_req.ack_intact && s_ack_range && (r_outs != '0)
                         && (32'(s_dist) < 32'(r_outs));
    assign s_freed     = OW'(s_dist) + OW'(1);
    assign s_outs_ack  = r_outs - s_freed;
    assign s_base_ack  = seq_inc(s_ack);

    assign s_walk_last = ((r_wcnt + OW'(1)) == r_outs);

    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_next    = r_next;
        n_outs    = r_outs;
        n_head    = r_head;
        n_waddr   = r_waddr;
        n_wseq    = r_wseq;
        n_wcnt    = r_wcnt;
        n_tseq    = r_tseq;
        s_ld      = 1'b0;
        s_ctl     = '0;
        s_pay     = '0;
        s_wr_en   = 1'b0;
        s_rd_en   = 1'b0;
        s_rd_addr = r_waddr;

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    s_ctl.last        = 1'b1;
                    s_ctl.window_full = s_full;
                    case (i_req.func)
                        FUNC_SEND: begin
                            s_ld = 1'b1;
                            if (s_full) begin
                                s_ctl.kind = KIND_REFUSED;
                            end else begin
                                s_wr_en           = 1'b1;
                                n_outs            = r_outs + OW'(1);
                                n_next            = seq_inc(r_next);
                                s_ctl.kind        = KIND_SENT;
                                s_ctl.pkt_seq     = SEQ_W'(r_next);
                                s_pay             = i_req.payload;
                                s_ctl.window_full = ((r_outs + OW'(1)) == OW'(WINDOW));
                                // start the timer only when the window was empty
                                if (r_outs == '0) begin
                                    s_ctl.timer_start     = 1'b1;
                                    s_ctl.timer_start_seq = SEQ_W'(r_next);
                                end
                            end
                        end
                        FUNC_ACK: begin
                            s_ld = 1'b1;
                            if (s_in_win) begin
                                n_outs               = s_outs_ack;
                                n_head               = ring_add(r_head, s_freed);
                                n_base               = s_base_ack;
                                s_ctl.kind           = KIND_ACKED;
                                s_ctl.window_full    = 1'b0;
                                s_ctl.timer_stop     = 1'b1;
                                s_ctl.timer_stop_seq = SEQ_W'(r_base);
                                if (s_outs_ack != '0) begin
                                    s_ctl.timer_start     = 1'b1;
                                    s_ctl.timer_start_seq = SEQ_W'(s_base_ack);
                                end
                            end else begin
                                s_ctl.kind = KIND_IGNORED;
                            end
                        end
                        FUNC_TIMEOUT: begin
                            if (r_outs == '0) begin
                                s_ld                  = 1'b1;
                                s_ctl.kind            = KIND_IGNORED;
                                s_ctl.timer_stop      = 1'b1;
                                s_ctl.timer_stop_seq  = i_req.timeout_seq;
                                s_ctl.timer_start     = 1'b1;
                                s_ctl.timer_start_seq = i_req.timeout_seq;
                            end else begin
                                // fetch the oldest packet, then walk the ring
                                s_rd_en   = 1'b1;
                                s_rd_addr = r_head;
                                n_waddr   = r_head;
                                n_wseq    = r_base;
                                n_wcnt    = '0;
                                n_tseq    = i_req.timeout_seq;
                                n_state   = S_WALK;
                            end
                        end
                        default: begin
                            s_ld       = 1'b1;
                            s_ctl.kind = KIND_IGNORED;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (s_out_free) begin
                    s_ld              = 1'b1;
                    s_ctl.kind        = KIND_RETX;
                    s_ctl.pkt_seq     = SEQ_W'(r_wseq);
                    s_pay             = s_rd_data;
                    s_ctl.window_full = s_full;
                    s_ctl.last        = s_walk_last;
                    if (r_wcnt == '0) begin
                        s_ctl.timer_stop      = 1'b1;
                        s_ctl.timer_stop_seq  = r_tseq;
                        s_ctl.timer_start     = 1'b1;
                        s_ctl.timer_start_seq = r_tseq;
                    end
                    if (s_walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        s_rd_en   = 1'b1;
                        s_rd_addr = ring_add(r_waddr, OW'(1));
                        n_waddr   = ring_add(r_waddr, OW'(1));
                        n_wseq    = seq_inc(r_wseq);
                        n_wcnt    = r_wcnt + OW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= SW'(1);
            r_next  <= SW'(1);
            r_outs  <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_next  <= n_next;
            r_outs  <= n_outs;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        r_wseq  <= n_wseq;
        r_wcnt  <= n_wcnt;
        r_tseq  <= n_tseq;
    end

    gbn_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (WINDOW),
        .AW    (RW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr (s_wr_addr),
        .i_wr_data (i_req.payload),
        .i_rd_en   (s_rd_en),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    gbn_out_stage #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (s_ld),
        .i_ctl     (s_ctl),
        .i_payload (s_pay),
        .o_free    (s_out_free),
        .o_rsp     (o_rsp)
    );

`ifndef ASSERT_OFF
    a_outs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_outs) <= WINDOW)
        else $error("outstanding count beyond window");

    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_wcnt < r_outs))
        else $error("ring walk past the outstanding packets");

    a_walk_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> ($stable(r_outs) && $stable(r_head)))
        else $error("window moved during retransmission");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ld |-> s_out_free)
        else $error("result loaded over a held item");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_wr_en |-> (r_state == S_IDLE))
        else $error("ring written during retransmission");
`endif

endmodule

`default_nettype wire
